// ===== rtl/sghi_pkg.sv =====
// Shared constants and controller/datapath handshake types for the hat interpolator.
`timescale 1ns / 1ps

package sghi_pkg;

    localparam int SURPLUS_BITS = 32;
    // floor(product * surplus / 2^FRAC) never exceeds |surplus| in magnitude
    localparam int CONTRIB_BITS = SURPLUS_BITS + 1;

    typedef struct packed {
        logic load;
        logic update;
        logic contrib;
        logic accum;
        logic emit;
    } sghi_cmd_t;

    typedef struct packed {
        logic last_dim;
        logic last_node;
        logic out_full;
    } sghi_status_t;

endpackage

// ===== rtl/sghi_if.sv =====
// Valid/ready channel interfaces for dimension beats and result beats.
`timescale 1ns / 1ps

interface sghi_in_if
    import sghi_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int INDEX_BITS = 11
);
    logic                           valid;
    logic                           ready;
    logic [FRAC_BITS:0]             coord;
    logic [INDEX_BITS-1:0]          level_index;
    logic [INDEX_BITS-1:0]          offset_index;
    logic signed [SURPLUS_BITS-1:0] node_surplus;
    logic                           last_dim;
    logic                           last_node;

    modport source (
        output valid, coord, level_index, offset_index, node_surplus, last_dim, last_node,
        input  ready
    );
    modport sink (
        input  valid, coord, level_index, offset_index, node_surplus, last_dim, last_node,
        output ready
    );
endinterface

interface sghi_out_if #(
    parameter int ACC_BITS = 48
);
    logic                       valid;
    logic                       ready;
    logic signed [ACC_BITS-1:0] interpolated_value;
    logic                       saturated;

    modport source (
        output valid, interpolated_value, saturated,
        input  ready
    );
    modport sink (
        input  valid, interpolated_value, saturated,
        output ready
    );
endinterface

// ===== rtl/sparse_grid_hat_interpolation.sv =====
// A dimension beat that is not a node's last is accepted, then its hat and product are formed.
// A node's last dimension goes on through hat/product, surplus multiply and accumulate; the last node adds an emit.
// The emit step loads the result beat into the output register after the final beat is accumulated;
// input is taken again while that result waits, unless a second result is already due.
// Asynchronous active-low reset sets the node product to one, clears the accumulator,
// the clip flag and the sequencer, and drops any pending result beat.
`timescale 1ns / 1ps

module sparse_grid_hat_interpolation
    import sghi_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int INDEX_BITS = 11,
    parameter int ACC_BITS   = 48
)
(
    input  logic    clk,
    input  logic    rst_n,
    sghi_in_if.sink    in_ch,
    sghi_out_if.source out_ch
);

    sghi_cmd_t    cmd;
    sghi_status_t status;

    sghi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sghi_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .INDEX_BITS (INDEX_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .coord              (in_ch.coord),
        .level_index        (in_ch.level_index),
        .offset_index       (in_ch.offset_index),
        .node_surplus       (in_ch.node_surplus),
        .last_dim           (in_ch.last_dim),
        .last_node          (in_ch.last_node),
        .cmd                (cmd),
        .status             (status),
        .out_valid          (out_ch.valid),
        .out_ready          (out_ch.ready),
        .interpolated_value (out_ch.interpolated_value),
        .saturated          (out_ch.saturated)
    );

endmodule

// ===== rtl/sghi_ctrl.sv =====
// Sequencer that steps each dimension beat through the datapath.
`timescale 1ns / 1ps

module sghi_ctrl
    import sghi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  sghi_status_t status,
    output sghi_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_MUL,
        S_ACC,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = status.last_dim ? S_MUL : S_IDLE;
            end
            S_MUL:
            begin
                cmd.contrib = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = status.last_node ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                // hold until the previous result beat has left
                if (!status.out_full)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/sghi_datapath.sv =====
// Hat value, node product, contribution and saturating accumulator registers.
`timescale 1ns / 1ps

module sghi_datapath
    import sghi_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int INDEX_BITS = 11,
    parameter int ACC_BITS   = 48
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [FRAC_BITS:0]             coord,
    input  logic [INDEX_BITS-1:0]          level_index,
    input  logic [INDEX_BITS-1:0]          offset_index,
    input  logic signed [SURPLUS_BITS-1:0] node_surplus,
    input  logic                           last_dim,
    input  logic                           last_node,
    input  sghi_cmd_t                      cmd,
    output sghi_status_t                   status,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [ACC_BITS-1:0]     interpolated_value,
    output logic                           saturated
);

    localparam int XI_W   = FRAC_BITS + 1 + INDEX_BITS;
    localparam int DIFF_W = XI_W + 1;
    localparam int CM_W   = FRAC_BITS + 2 + SURPLUS_BITS;

    localparam logic [FRAC_BITS:0]        ONE_Q   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [DIFF_W-1:0]  ONE_D   = DIFF_W'(ONE_Q);
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    logic [XI_W-1:0]                xi_reg;
    logic [INDEX_BITS-1:0]          oi_reg;
    logic signed [SURPLUS_BITS-1:0] surplus_reg;
    logic                           last_dim_reg;
    logic                           last_node_reg;
    logic [FRAC_BITS:0]             prod_reg;
    logic                           killed_reg;
    logic signed [CONTRIB_BITS-1:0] contrib_reg;
    logic signed [ACC_BITS-1:0]     acc_reg;
    logic                           clip_reg;
    logic                           out_valid_reg;
    logic signed [ACC_BITS-1:0]     out_value_reg;
    logic                           out_sat_reg;

    logic [XI_W-1:0]                oi_q;
    logic signed [DIFF_W-1:0]       diff;
    logic signed [DIFF_W-1:0]       dist_abs;
    logic                           hat_pos;
    logic [FRAC_BITS:0]             hat;
    logic [2*FRAC_BITS+1:0]         prod_mul;
    logic signed [CM_W-1:0]         cm;
    logic signed [CM_W-1:0]         cm_sh;
    logic signed [ACC_BITS:0]       sum_wide;
    logic                           ovf;

    // distance |x*i - j| and hat value 1 - distance
    assign oi_q     = {1'b0, oi_reg, {FRAC_BITS{1'b0}}};
    assign diff     = $signed({1'b0, xi_reg}) - $signed({1'b0, oi_q});
    assign dist_abs = diff[DIFF_W-1] ? -diff : diff;
    assign hat_pos  = (dist_abs < ONE_D);
    assign hat      = ONE_Q - dist_abs[FRAC_BITS:0];
    assign prod_mul = prod_reg * hat;

    // arithmetic shift floors toward minus infinity
    assign cm    = $signed({1'b0, prod_reg}) * surplus_reg;
    assign cm_sh = cm >>> FRAC_BITS;

    assign sum_wide = (ACC_BITS+1)'(acc_reg) + (ACC_BITS+1)'(contrib_reg);
    assign ovf      = (sum_wide[ACC_BITS] != sum_wide[ACC_BITS-1]);

    assign status.last_dim  = last_dim_reg;
    assign status.last_node = last_node_reg;
    assign status.out_full  = out_valid_reg;

    assign out_valid          = out_valid_reg;
    assign interpolated_value = out_value_reg;
    assign saturated          = out_sat_reg;

    // beat capture; the first multiply runs straight off the input
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xi_reg        <= XI_W'(coord * level_index);
            oi_reg        <= offset_index;
            surplus_reg   <= node_surplus;
            last_dim_reg  <= last_dim;
            last_node_reg <= last_node;
        end
        if (cmd.contrib)
        begin
            contrib_reg <= killed_reg ? '0 : cm_sh[CONTRIB_BITS-1:0];
        end
        if (cmd.emit)
        begin
            out_value_reg <= acc_reg;
            out_sat_reg   <= clip_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg      <= ONE_Q;
            killed_reg    <= 1'b0;
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update && !killed_reg)
            begin
                if (hat_pos)
                begin
                    prod_reg <= prod_mul[2*FRAC_BITS:FRAC_BITS];
                end
                else
                begin
                    killed_reg <= 1'b1;
                end
            end
            if (cmd.accum)
            begin
                if (ovf)
                begin
                    acc_reg  <= sum_wide[ACC_BITS] ? ACC_MIN : ACC_MAX;
                    clip_reg <= 1'b1;
                end
                else
                begin
                    acc_reg <= sum_wide[ACC_BITS-1:0];
                end
                // restart node state for the next node
                prod_reg   <= ONE_Q;
                killed_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                acc_reg  <= '0;
                clip_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== tb/sghi_sum_checker.sv =====
// Checker for the hat interpolator: predicts result beats from dimension beats and compares.
`timescale 1ns / 1ps

module sghi_sum_checker
    import sghi_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int INDEX_BITS = 11,
    parameter int ACC_BITS   = 48
)
(
    input  logic clk,
    input  logic rst_n,
    sghi_in_if   dim_mon,
    sghi_out_if  sum_mon,
    output int   fail_count,
    output int   open_results
);

    localparam longint GAIN_ONE = longint'(1) <<< FRAC_BITS;
    localparam longint SUM_MAX  = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    localparam longint SUM_MIN  = -SUM_MAX - 1;

    typedef struct packed {
        logic [ACC_BITS-1:0] value;
        logic                clipped;
    } sum_beat_t;

    sum_beat_t due_sums[$];

    longint node_gain;
    bit     node_dead;
    longint acc_sum;
    bit     acc_clipped;
    int     misses;

    initial
    begin
        fail_count   = 0;
        open_results = 0;
        misses       = 0;
    end

    // Fold one dimension beat into the node product and the running sum.
    function automatic void fold_dim(
        input logic [FRAC_BITS:0]           x,
        input logic [INDEX_BITS-1:0]        li,
        input logic [INDEX_BITS-1:0]        oj,
        input logic signed [SURPLUS_BITS-1:0] surplus,
        input logic                         ld,
        input logic                         ln
    );
        longint diff;
        longint dist_abs;
        longint hat;
        longint share;
        longint total;
        sum_beat_t beat;
        if (!node_dead)
        begin
            diff     = longint'(x) * longint'(li) - (longint'(oj) <<< FRAC_BITS);
            dist_abs = (diff < 0) ? -diff : diff;
            hat      = GAIN_ONE - dist_abs;
            if (hat <= 0)
                node_dead = 1'b1;
            else
                node_gain = (node_gain * hat) >>> FRAC_BITS;
        end
        if (ld)
        begin
            if (!node_dead)
            begin
                // arithmetic shift rounds toward minus infinity
                share = (node_gain * longint'(surplus)) >>> FRAC_BITS;
                total = acc_sum + share;
                if (total > SUM_MAX)
                begin
                    acc_sum     = SUM_MAX;
                    acc_clipped = 1'b1;
                end
                else if (total < SUM_MIN)
                begin
                    acc_sum     = SUM_MIN;
                    acc_clipped = 1'b1;
                end
                else
                begin
                    acc_sum = total;
                end
            end
            node_gain = GAIN_ONE;
            node_dead = 1'b0;
            if (ln)
            begin
                beat.value   = acc_sum[ACC_BITS-1:0];
                beat.clipped = acc_clipped;
                due_sums.push_back(beat);
                acc_sum     = 0;
                acc_clipped = 1'b0;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sum_beat_t want;
        if (!rst_n)
        begin
            node_gain   = GAIN_ONE;
            node_dead   = 1'b0;
            acc_sum     = 0;
            acc_clipped = 1'b0;
            due_sums.delete();
            open_results <= 0;
        end
        else
        begin
            if (dim_mon.valid && dim_mon.ready)
                fold_dim(dim_mon.coord, dim_mon.level_index, dim_mon.offset_index,
                         dim_mon.node_surplus, dim_mon.last_dim, dim_mon.last_node);
            if (sum_mon.valid && sum_mon.ready)
            begin
                if (due_sums.size() == 0)
                begin
                    misses++;
                    if (misses <= 10)
                        $display("unexpected result beat: value %0d saturated %0b",
                                 sum_mon.interpolated_value, sum_mon.saturated);
                end
                else
                begin
                    want = due_sums.pop_front();
                    if (want.value !== sum_mon.interpolated_value ||
                        want.clipped !== sum_mon.saturated)
                    begin
                        misses++;
                        if (misses <= 10)
                            $display("result mismatch: expected %0d sat %0b, got %0d sat %0b",
                                     $signed(want.value), want.clipped,
                                     sum_mon.interpolated_value, sum_mon.saturated);
                    end
                end
            end
            open_results <= due_sums.size();
            fail_count   <= misses;
        end
    end

endmodule

// ===== tb/tb_sparse_grid_hat_interpolation.sv =====
// Testbench top for the hat interpolator: stimulus, receiver stalls, timeout and verdict.
`timescale 1ns / 1ps

module tb_sparse_grid_hat_interpolation
    import sghi_pkg::*;
();

    localparam int FRAC_BITS   = 16;
    localparam int INDEX_BITS  = 11;
    localparam int ACC_BITS    = 48;
    localparam int COORD_ONE   = 1 << FRAC_BITS;
    localparam int RANDOM_DIMS = 950;
    localparam int LONG_HOLD   = 300;

    logic clk = 1'b0;
    logic rst_n;

    int tx_max_gap = 12;
    int rx_max_gap = 12;
    int dims_sent  = 0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;
    int fail_count;
    int open_results;

    sghi_in_if  #(.FRAC_BITS(FRAC_BITS), .INDEX_BITS(INDEX_BITS)) dim_ch ();
    sghi_out_if #(.ACC_BITS(ACC_BITS)) sum_ch ();

    sparse_grid_hat_interpolation #(
        .FRAC_BITS  (FRAC_BITS),
        .INDEX_BITS (INDEX_BITS),
        .ACC_BITS   (ACC_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (dim_ch),
        .out_ch (sum_ch)
    );

    sghi_sum_checker #(
        .FRAC_BITS  (FRAC_BITS),
        .INDEX_BITS (INDEX_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .dim_mon      (dim_ch),
        .sum_mon      (sum_ch),
        .fail_count   (fail_count),
        .open_results (open_results)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offer one dimension beat after a random gap; return once it is taken.
    task automatic send_dim(
        input logic [FRAC_BITS:0]             x,
        input logic [INDEX_BITS-1:0]          li,
        input logic [INDEX_BITS-1:0]          oj,
        input logic signed [SURPLUS_BITS-1:0] surplus,
        input logic                           ld,
        input logic                           ln
    );
        int gap;
        gap = $urandom_range(tx_max_gap, 0);
        if (gap > 0)
        begin
            dim_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        dim_ch.valid        <= 1'b1;
        dim_ch.coord        <= x;
        dim_ch.level_index  <= li;
        dim_ch.offset_index <= oj;
        dim_ch.node_surplus <= surplus;
        dim_ch.last_dim     <= ld;
        dim_ch.last_node    <= ln;
        @(posedge clk);
        while (!dim_ch.ready) @(posedge clk);
        dims_sent++;
    endtask

    // Send a set of nodes, framed to end in one result; mostly near-peak hats, some noise.
    task automatic send_result_set();
        int nodes;
        int dims;
        int li;
        int lj;
        longint target;
        logic [FRAC_BITS:0] x;
        logic signed [SURPLUS_BITS-1:0] surplus;
        logic ld;
        logic ln;
        nodes = $urandom_range(5, 1);
        if ($urandom_range(9, 0) == 0)
            nodes = $urandom_range(12, 6);
        for (int n = 0; n < nodes; n++)
        begin
            dims = $urandom_range(4, 1);
            for (int d = 0; d < dims; d++)
            begin
                ld = (d == dims - 1);
                ln = ld && (n == nodes - 1);
                if (!ld && $urandom_range(19, 0) == 0)
                    ln = 1'b1;
                if ($urandom_range(99, 0) < 12)
                begin
                    x  = 17'($urandom);
                    li = $urandom_range(2047, 0);
                    lj = $urandom_range(2047, 0);
                    // drop the framing now and then
                    if ($urandom_range(9, 0) == 0)
                    begin
                        ld = 1'($urandom_range(1, 0));
                        ln = 1'($urandom_range(1, 0));
                    end
                end
                else
                begin
                    li = ($urandom_range(1, 0) == 1) ? $urandom_range(15, 0)
                                                     : $urandom_range(2047, 0);
                    lj = $urandom_range(li, 0);
                    target = longint'(lj) * COORD_ONE
                           + longint'($urandom_range(2 * COORD_ONE - 2, 0)) - (COORD_ONE - 1);
                    if (target < 0)
                        target = 0;
                    if (target > longint'(li) * COORD_ONE)
                        target = longint'(li) * COORD_ONE;
                    if (li == 0)
                        x = 17'($urandom_range(COORD_ONE, 0));
                    else
                        x = 17'(target / li);
                end
                surplus = $urandom;
                case ($urandom_range(3, 0))
                    0: surplus = {{20{surplus[11]}}, surplus[11:0]};
                    1: surplus = surplus[0] ? 32'sh7fff_ffff : 32'sh8000_0000;
                    default: ;
                endcase
                send_dim(x, 11'(li), 11'(lj), surplus, ld, ln);
            end
        end
    endtask

    initial
    begin
        int set_idx;
        rst_n               <= 1'b0;
        dim_ch.valid        <= 1'b0;
        dim_ch.coord        <= '0;
        dim_ch.level_index  <= '0;
        dim_ch.offset_index <= '0;
        dim_ch.node_surplus <= '0;
        dim_ch.last_dim     <= 1'b0;
        dim_ch.last_node    <= 1'b0;
        sum_ch.ready        <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full hat at both index extremes, max and min surplus
        send_dim(17'd0, 11'd0, 11'd0, 32'sh7fff_ffff, 1'b1, 1'b1);
        send_dim(17'd65536, 11'd2047, 11'd2047, 32'sh8000_0000, 1'b1, 1'b1);
        // killed node: later dimensions ignored; last_node without last_dim
        send_dim(17'd0, 11'd0, 11'd1, 32'sh0000_1234, 1'b0, 1'b0);
        send_dim(17'd65536, 11'd1, 11'd1, 32'sh0000_5678, 1'b0, 1'b1);
        send_dim(17'd65536, 11'd1, 11'd1, 32'sh0000_0005, 1'b1, 1'b0);
        // half hat, near-one hat, coordinate above one; floor of a tiny negative
        send_dim(17'd32768, 11'd1, 11'd0, 32'sh0000_0000, 1'b0, 1'b0);
        send_dim(17'd1, 11'd1, 11'd0, 32'sh0000_0000, 1'b0, 1'b0);
        send_dim(17'd131071, 11'd1, 11'd2, -32'sd1, 1'b1, 1'b0);
        // hat exactly zero, hat negative, far off the peak
        send_dim(17'd32768, 11'd2, 11'd0, 32'sh7fff_ffff, 1'b1, 1'b0);
        send_dim(17'd65536, 11'd2047, 11'd0, 32'sh7fff_ffff, 1'b1, 1'b0);
        send_dim(17'd0, 11'd2047, 11'd2047, 32'sh7fff_ffff, 1'b1, 1'b0);
        send_dim(17'd65535, 11'd2047, 11'd2047, 32'sh1234_5678, 1'b1, 1'b0);
        send_dim(17'd65536, 11'd1, 11'd1, 32'sh0000_0000, 1'b1, 1'b0);
        send_dim(17'd40000, 11'd3, 11'd2, 32'sh8000_0001, 1'b1, 1'b1);

        // open with a long receiver hold-off while beats keep coming
        tx_max_gap   = 0;
        rx_max_gap   = 12;
        hold_request <= 1'b1;
        dims_sent    = 0;
        set_idx      = 0;
        while (dims_sent < RANDOM_DIMS)
        begin
            if (set_idx > 0 && set_idx % 10 == 0)
            begin
                case ($urandom_range(3, 0))
                    0:
                    begin
                        tx_max_gap = 12;
                        rx_max_gap = 12;
                    end
                    1:
                    begin
                        tx_max_gap = 0;
                        rx_max_gap = 0;
                    end
                    2:
                    begin
                        tx_max_gap = 0;
                        rx_max_gap = 12;
                    end
                    default:
                    begin
                        tx_max_gap = 12;
                        rx_max_gap = 0;
                    end
                endcase
            end
            send_result_set();
            set_idx++;
        end
        dim_ch.valid <= 1'b0;

        @(posedge clk);
        while (open_results != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && open_results == 0)
            $display("PASS sparse_grid_hat_interpolation");
        else
            $display("FAIL sparse_grid_hat_interpolation");
        $finish;
    end

    // Result receiver: random ready gaps, one long hold-off when asked.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                gap       = LONG_HOLD;
                hold_done = 1'b1;
            end
            else
            begin
                gap = $urandom_range(rx_max_gap, 0);
            end
            if (gap > 0)
            begin
                sum_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            sum_ch.ready <= 1'b1;
            @(posedge clk);
            while (!sum_ch.valid) @(posedge clk);
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAIL sparse_grid_hat_interpolation");
        $finish;
    end

endmodule

// ===== sparse_grid_hat_interpolation.f =====
rtl/sghi_pkg.sv
rtl/sghi_if.sv
rtl/sghi_ctrl.sv
rtl/sghi_datapath.sv
rtl/sparse_grid_hat_interpolation.sv
tb/sghi_sum_checker.sv
tb/tb_sparse_grid_hat_interpolation.sv
